// ===== rtl/core/hfdd_pkg.sv =====
// Shared types and constants of the Huffman first-difference decoder.
// No dependencies; every module of the block imports this package.

package hfdd_pkg;

    localparam int NODE_DEPTH = 1024;
    localparam int NODE_AW    = $clog2(NODE_DEPTH);
    localparam int MAX_LINE   = 1024;

    localparam int IDX_W   = 10;
    localparam int LEN_W   = 11;
    localparam int PIX_W   = 8;
    localparam int VAL_W   = 10;
    localparam int TDATA_W = 56;

    localparam logic [LEN_W-1:0] LINE_LEN_RESET = LEN_W'(800);

    typedef enum logic [1:0] {
        FUNC_LOAD  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_BYTE  = 2'd2
    } t_func;

    typedef enum logic {
        REG_ROOT_INDEX  = 1'b0,
        REG_LINE_LENGTH = 1'b1
    } t_cfg_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_ROOT,
        ST_RD_WALK,
        ST_STEP,
        ST_FINISH
    } t_state;

    // one node table entry
    typedef struct packed {
        logic             leaf;
        logic [VAL_W-1:0] val;
        logic [IDX_W-1:0] left;
        logic [IDX_W-1:0] right;
    } t_node;

    // input item payload, lowest field in the lowest bits
    typedef struct packed {
        logic [6:0]       pad;
        logic [VAL_W-1:0] leaf_value;
        logic             leaf_flag;
        logic [IDX_W-1:0] right_child;
        logic [IDX_W-1:0] left_child;
        logic [IDX_W-1:0] node_addr;
        logic [PIX_W-1:0] byte_in;
    } t_in_data;

    typedef struct packed {
        logic [IDX_W-1:0] root_index;
        logic [LEN_W-1:0] line_length;
    } t_cfg;

    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        t_node            wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } t_ram_req;

endpackage

// ===== rtl/core/hfdd_node_ram.sv =====
// Node table: single write port, one registered read port.
// Depends on hfdd_pkg. Addresses beyond the table ignore writes and read zero.

module hfdd_node_ram import hfdd_pkg::*; (
    input  logic     i_clk,
    input  t_ram_req i_req,
    output t_node    o_rd_data
);

    t_node mem [NODE_DEPTH];
    t_node r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we && (int'(i_req.waddr) < NODE_DEPTH)) begin
            mem[i_req.waddr[NODE_AW-1:0]] <= i_req.wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.re) begin
            if (int'(i_req.raddr) < NODE_DEPTH) begin
                r_rd_data <= mem[i_req.raddr[NODE_AW-1:0]];
            end else begin
                r_rd_data <= '0;
            end
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/core/hfdd_walker.sv =====
// Tree walker: shifts a code byte out one bit per cycle when not stalled and steps
// the node table once per bit; holds the line and output registers. Uses hfdd_pkg.

module hfdd_walker import hfdd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cfg               i_cfg,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [PIX_W-1:0]   m_axis_tdata,
    output logic               m_axis_tlast,
    output t_ram_req           o_ram_req,
    input  t_node              i_rd_data
);

    t_state           r_state, n_state;
    logic [PIX_W-1:0] r_shift, n_shift;
    logic [2:0]       r_left, n_left;
    t_node            r_root_ent, n_root_ent;
    logic [IDX_W-1:0] r_walk, n_walk;
    logic [IDX_W-1:0] r_rd_addr, n_rd_addr;
    logic [PIX_W-1:0] r_prev, n_prev;
    logic [LEN_W-1:0] r_count, n_count;
    logic             r_stopped, n_stopped;
    logic [PIX_W-1:0] r_pend, n_pend;
    logic             r_pend_valid, n_pend_valid;
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_pixel, n_out_pixel;
    logic             r_out_last, n_out_last;

    t_in_data         in_d;
    t_func            func;
    logic [LEN_W-1:0] limit;
    logic             out_free;
    logic             accept;
    logic [PIX_W-1:0] pix;
    t_node            next_ent;
    logic [IDX_W-1:0] next_idx;

    assign in_d     = t_in_data'(s_axis_tdata);
    assign func     = t_func'(s_axis_tuser);
    assign limit    = (int'(i_cfg.line_length) > MAX_LINE) ? LEN_W'(MAX_LINE)
                                                          : i_cfg.line_length;
    assign out_free = !r_out_valid || m_axis_tready;
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign pix      = r_prev - i_rd_data.val[PIX_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_shift      = r_shift;
        n_left       = r_left;
        n_root_ent   = r_root_ent;
        n_walk       = r_walk;
        n_prev       = r_prev;
        n_count      = r_count;
        n_stopped    = r_stopped;
        n_pend       = r_pend;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && !m_axis_tready;
        n_out_pixel  = r_out_pixel;
        n_out_last   = r_out_last;
        next_ent     = i_rd_data;
        next_idx     = r_rd_addr;
        s_axis_tready   = 1'b0;
        o_ram_req       = '0;
        o_ram_req.re    = 1'b1;
        o_ram_req.raddr = r_rd_addr;
        o_ram_req.waddr = in_d.node_addr;
        o_ram_req.wdata = '{leaf: in_d.leaf_flag, val: in_d.leaf_value,
                            left: in_d.left_child, right: in_d.right_child};

        case (r_state)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                if (accept) begin
                    case (func)
                        FUNC_LOAD: begin
                            o_ram_req.we = 1'b1;
                        end
                        FUNC_START: begin
                            n_walk = i_cfg.root_index;
                            n_prev = in_d.byte_in;
                            if (limit == '0) begin
                                n_count   = '0;
                                n_stopped = 1'b1;
                            end else begin
                                n_count      = LEN_W'(1);
                                n_stopped    = (limit <= LEN_W'(1));
                                n_pend       = in_d.byte_in;
                                n_pend_valid = 1'b1;
                                n_state      = ST_FINISH;
                            end
                        end
                        FUNC_BYTE: begin
                            if (!r_stopped) begin
                                n_shift         = in_d.byte_in;
                                o_ram_req.raddr = i_cfg.root_index;
                                n_state         = ST_RD_ROOT;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ST_RD_ROOT: begin
                n_root_ent      = i_rd_data;
                o_ram_req.raddr = r_walk;
                n_state         = ST_RD_WALK;
            end
            ST_RD_WALK: begin
                if (i_rd_data.leaf) begin
                    o_ram_req.raddr = r_walk;
                end else begin
                    o_ram_req.raddr = r_shift[PIX_W-1] ? i_rd_data.left : i_rd_data.right;
                end
                n_shift = r_shift << 1;
                n_left  = 3'd7;
                n_state = ST_STEP;
            end
            ST_STEP: begin
                if (r_stopped) begin
                    o_ram_req.re = 1'b0;
                    n_state      = ST_FINISH;
                end else if (i_rd_data.leaf && r_pend_valid && !out_free) begin
                    o_ram_req.re = 1'b0;
                end else begin
                    if (i_rd_data.leaf) begin
                        n_prev    = pix;
                        n_count   = r_count + LEN_W'(1);
                        n_stopped = (n_count >= limit);
                        if (r_pend_valid) begin
                            n_out_valid = 1'b1;
                            n_out_pixel = r_pend;
                            n_out_last  = 1'b0;
                        end
                        n_pend       = pix;
                        n_pend_valid = 1'b1;
                        n_walk       = i_cfg.root_index;
                        next_ent     = r_root_ent;
                        next_idx     = i_cfg.root_index;
                    end else begin
                        n_walk = r_rd_addr;
                    end
                    if (r_left == 3'd0) begin
                        o_ram_req.re = 1'b0;
                        n_state      = ST_FINISH;
                    end else begin
                        if (next_ent.leaf) begin
                            o_ram_req.raddr = next_idx;
                        end else begin
                            o_ram_req.raddr = r_shift[PIX_W-1] ? next_ent.left
                                                               : next_ent.right;
                        end
                        n_shift = r_shift << 1;
                        n_left  = r_left - 3'd1;
                    end
                end
            end
            ST_FINISH: begin
                o_ram_req.re = 1'b0;
                if (!r_pend_valid) begin
                    n_state = ST_IDLE;
                end else if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_pixel  = r_pend;
                    n_out_last   = 1'b1;
                    n_pend_valid = 1'b0;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign n_rd_addr = o_ram_req.re ? o_ram_req.raddr : r_rd_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_left       <= '0;
            r_walk       <= '0;
            r_prev       <= '0;
            r_count      <= '0;
            r_stopped    <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_left       <= n_left;
            r_walk       <= n_walk;
            r_prev       <= n_prev;
            r_count      <= n_count;
            r_stopped    <= n_stopped;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift     <= n_shift;
        r_root_ent  <= n_root_ent;
        r_rd_addr   <= n_rd_addr;
        r_pend      <= n_pend;
        r_out_pixel <= n_out_pixel;
        r_out_last  <= n_out_last;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pixel;
    assign m_axis_tlast  = r_out_last;

    // held pixel is always flushed before a new item is taken
    a_idle_no_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_IDLE |-> !r_pend_valid)
        else $error("pending pixel left in idle");

    a_root_then_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_RD_ROOT |=> r_state == ST_RD_WALK)
        else $error("root fetch not followed by walk fetch");

    a_stop_ends_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_STEP && r_stopped) |=> r_state == ST_FINISH)
        else $error("walk continued on a full line");

    a_flush_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH && r_pend_valid && out_free)
            |=> (m_axis_tvalid && m_axis_tlast && r_state == ST_IDLE))
        else $error("final pixel not marked last");

endmodule

// ===== rtl/core/huffman_first_difference_decoder_unit.sv =====
// A load item writes the node table in the same cycle in which it is taken. A start item is
// taken and then, from the finish state, its pixel is handed to the output register. A
// compressed byte runs through two node table reads to fetch the root and the current
// node, one cycle per code bit while the output keeps up (the single table read port is
// stepped once per bit, each step depending on the last), and a finish state that hands
// over the final pixel; a stalled output adds its wait, and a byte that fills the line
// stops stepping in the cycle after the pixel that filled it. A byte that arrives on a
// full line is taken without a table walk. The node table needs no clearing after reset.

module huffman_first_difference_decoder_unit import hfdd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [LEN_W-1:0]   i_cfg_data,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    // byte_in[7:0], node_addr[17:8], left_child[27:18], right_child[37:28],
    // leaf_flag[38], leaf_value[48:39], zero fill above
    input  logic [TDATA_W-1:0] s_axis_tdata,
    // func[1:0]
    input  logic [1:0]         s_axis_tuser,
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    // pixel[7:0]
    output logic [PIX_W-1:0]   m_axis_tdata,
    output logic               m_axis_tlast
);

    logic [IDX_W-1:0] r_root_index;
    logic [LEN_W-1:0] r_line_length;
    t_cfg             cfg;
    t_ram_req         ram_req;
    t_node            rd_data;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_root_index  <= '0;
            r_line_length <= LINE_LEN_RESET;
        end else if (i_cfg_valid) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_ROOT_INDEX:  r_root_index  <= i_cfg_data[IDX_W-1:0];
                REG_LINE_LENGTH: r_line_length <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign cfg = '{root_index: r_root_index, line_length: r_line_length};

    hfdd_node_ram u_node_ram (
        .i_clk     (i_clk),
        .i_req     (ram_req),
        .o_rd_data (rd_data)
    );

    hfdd_walker u_walker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (cfg),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .o_ram_req     (ram_req),
        .i_rd_data     (rd_data)
    );

endmodule

// ===== dv/hfdd_pixel_checker.sv =====
// Checker for the Huffman first-difference decoder: follows node loads, register writes
// and accepted items, predicts every decoded pixel and compares the output stream.
// Depends on hfdd_pkg.

module hfdd_pixel_checker import hfdd_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    input  logic               i_cfg_ready,
    input  logic               i_cfg_index,
    input  logic [LEN_W-1:0]   i_cfg_data,
    input  logic               i_item_valid,
    input  logic               i_item_ready,
    input  logic [TDATA_W-1:0] i_item_data,
    input  logic [1:0]         i_item_func,
    input  logic               i_pix_valid,
    input  logic               i_pix_ready,
    input  logic [PIX_W-1:0]   i_pix_data,
    input  logic               i_pix_last,
    output int                 o_fail_count,
    output int                 o_pixels_owed
);

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             last;
    } t_pixel_out;

    t_node            tree [NODE_DEPTH];
    logic [IDX_W-1:0] root_sel;
    logic [LEN_W-1:0] line_len;
    logic [IDX_W-1:0] walk_at;
    logic [PIX_W-1:0] prev_pix;
    int               pix_count;
    bit               line_full;
    t_pixel_out       pixels_due [$];

    function automatic int line_limit();
        return (line_len > MAX_LINE) ? MAX_LINE : int'(line_len);
    endfunction

    task automatic decode_item(logic [1:0] func, t_in_data d);
        logic [IDX_W-1:0] hit;
        int               emitted;
        emitted = 0;
        if (func == FUNC_LOAD) begin
            tree[d.node_addr] = '{leaf: d.leaf_flag, val: d.leaf_value,
                                  left: d.left_child, right: d.right_child};
        end else if (func == FUNC_START) begin
            walk_at  = root_sel;
            prev_pix = d.byte_in;
            if (line_limit() == 0) begin
                pix_count = 0;
                line_full = 1'b1;
            end else begin
                pix_count = 1;
                line_full = (pix_count >= line_limit());
                pixels_due.push_back('{pixel: d.byte_in, last: 1'b1});
            end
        end else if (func == FUNC_BYTE) begin
            for (int b = PIX_W - 1; b >= 0; b--) begin
                if (line_full) break;
                if (tree[walk_at].leaf)
                    hit = walk_at;
                else
                    hit = d.byte_in[b] ? tree[walk_at].left : tree[walk_at].right;
                if (tree[hit].leaf) begin
                    prev_pix = prev_pix - tree[hit].val[PIX_W-1:0];
                    pixels_due.push_back('{pixel: prev_pix, last: 1'b0});
                    emitted++;
                    pix_count++;
                    walk_at = root_sel;
                    if (pix_count >= line_limit()) line_full = 1'b1;
                end else begin
                    walk_at = hit;
                end
            end
            if (emitted > 0) pixels_due[pixels_due.size() - 1].last = 1'b1;
        end
    endtask

    always @(posedge i_clk) begin
        t_pixel_out due;
        if (!i_rst_n) begin
            root_sel     = '0;
            line_len     = LINE_LEN_RESET;
            walk_at      = '0;
            prev_pix     = '0;
            pix_count    = 0;
            line_full    = 1'b0;
            o_fail_count = 0;
            pixels_due.delete();
        end else begin
            if (i_pix_valid && i_pix_ready) begin
                if (pixels_due.size() == 0) begin
                    $error("pixel: expected none, got %0d", i_pix_data);
                    o_fail_count++;
                end else begin
                    due = pixels_due.pop_front();
                    if (i_pix_data !== due.pixel) begin
                        $error("pixel: expected %0d, got %0d", due.pixel, i_pix_data);
                        o_fail_count++;
                    end
                    if (i_pix_last !== due.last) begin
                        $error("last: expected %0d, got %0d", due.last, i_pix_last);
                        o_fail_count++;
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_ROOT_INDEX)
                    root_sel = i_cfg_data[IDX_W-1:0];
                else
                    line_len = i_cfg_data;
            end
            if (i_item_valid && i_item_ready) decode_item(i_item_func, t_in_data'(i_item_data));
        end
        o_pixels_owed <= pixels_due.size();
    end

endmodule

// ===== dv/tb_huffman_first_difference_decoder_unit.sv =====
// Testbench top for huffman_first_difference_decoder_unit: builds node tables, programs
// the registers between phases and streams lines with random idling on both sides.
// Depends on hfdd_pkg, the decoder RTL and hfdd_pixel_checker.

module tb_huffman_first_difference_decoder_unit;
    import hfdd_pkg::*;

    localparam logic [1:0] FUNC_UNKNOWN = 2'd3;
    localparam int         SETTLE_CYC   = 24;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic               i_cfg_index;
    logic [LEN_W-1:0]   i_cfg_data;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [PIX_W-1:0]   m_axis_tdata;
    logic               m_axis_tlast;

    int               fail_count;
    int               pixels_owed;
    bit               steady_flow;
    int               items_sent;
    bit               node_written [NODE_DEPTH];
    logic [IDX_W-1:0] written_nodes [$];

    huffman_first_difference_decoder_unit uut (.*);

    hfdd_pixel_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_item_valid  (s_axis_tvalid),
        .i_item_ready  (s_axis_tready),
        .i_item_data   (s_axis_tdata),
        .i_item_func   (s_axis_tuser),
        .i_pix_valid   (m_axis_tvalid),
        .i_pix_ready   (m_axis_tready),
        .i_pix_data    (m_axis_tdata),
        .i_pix_last    (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pixels_owed (pixels_owed)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    initial begin
        #2000000;
        $display("tb_huffman_first_difference_decoder_unit NOT OK");
        $finish;
    end

    function automatic int draw_gap();
        return steady_flow ? 0 : $urandom_range(0, 9);
    endfunction

    function automatic t_in_data random_payload();
        t_in_data p;
        p.pad         = '0;
        p.byte_in     = PIX_W'($urandom_range(0, 255));
        p.node_addr   = IDX_W'($urandom_range(0, NODE_DEPTH - 1));
        p.left_child  = IDX_W'($urandom_range(0, NODE_DEPTH - 1));
        p.right_child = IDX_W'($urandom_range(0, NODE_DEPTH - 1));
        p.leaf_flag   = 1'($urandom_range(0, 1));
        p.leaf_value  = VAL_W'($urandom_range(0, 1023));
        return p;
    endfunction

    function automatic logic [IDX_W-1:0] any_written_node();
        return written_nodes[$urandom_range(0, written_nodes.size() - 1)];
    endfunction

    // valid stays high across back-to-back items; settle() drops it when the stream pauses
    task automatic push_item(logic [1:0] func, t_in_data payload);
        int gap;
        gap = draw_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= payload;
        s_axis_tuser  <= func;
        do @(posedge i_clk); while (!s_axis_tready);
        if (func != FUNC_UNKNOWN) items_sent++;
    endtask

    task automatic load_node(logic [IDX_W-1:0] addr, logic leaf, logic [VAL_W-1:0] val,
                             logic [IDX_W-1:0] left, logic [IDX_W-1:0] right);
        t_in_data p;
        p             = random_payload();
        p.node_addr   = addr;
        p.leaf_flag   = leaf;
        p.leaf_value  = val;
        p.left_child  = left;
        p.right_child = right;
        push_item(FUNC_LOAD, p);
        if (!node_written[addr]) begin
            node_written[addr] = 1'b1;
            written_nodes.push_back(addr);
        end
    endtask

    // internal nodes only ever point at written entries
    task automatic stray_load();
        logic [IDX_W-1:0] addr;
        addr = IDX_W'($urandom_range(0, NODE_DEPTH - 1));
        if ($urandom_range(0, 1))
            load_node(addr, 1'b1, VAL_W'($urandom_range(0, 1023)),
                      IDX_W'($urandom_range(0, NODE_DEPTH - 1)),
                      IDX_W'($urandom_range(0, NODE_DEPTH - 1)));
        else
            load_node(addr, 1'b0, VAL_W'($urandom_range(0, 1023)), any_written_node(),
                      any_written_node());
    endtask

    task automatic build_tree(int leaves, output logic [IDX_W-1:0] root);
        logic [IDX_W-1:0] subtrees [$];
        logic [IDX_W-1:0] addr;
        logic [IDX_W-1:0] l;
        logic [IDX_W-1:0] r;
        int               k;
        for (int i = 0; i < leaves; i++) begin
            addr = IDX_W'($urandom_range(0, NODE_DEPTH - 1));
            load_node(addr, 1'b1, VAL_W'($urandom_range(0, 1023)),
                      IDX_W'($urandom_range(0, NODE_DEPTH - 1)),
                      IDX_W'($urandom_range(0, NODE_DEPTH - 1)));
            subtrees.push_back(addr);
        end
        while (subtrees.size() > 1) begin
            k = $urandom_range(0, subtrees.size() - 1);
            l = subtrees[k];
            subtrees.delete(k);
            k = $urandom_range(0, subtrees.size() - 1);
            r = subtrees[k];
            subtrees.delete(k);
            addr = IDX_W'($urandom_range(0, NODE_DEPTH - 1));
            load_node(addr, 1'b0, VAL_W'($urandom_range(0, 1023)), l, r);
            subtrees.push_back(addr);
        end
        root = subtrees[0];
    endtask

    task automatic start_line(logic [PIX_W-1:0] first_pix);
        t_in_data p;
        p         = random_payload();
        p.byte_in = first_pix;
        push_item(FUNC_START, p);
    endtask

    task automatic code_byte(logic [PIX_W-1:0] code);
        t_in_data p;
        p         = random_payload();
        p.byte_in = code;
        push_item(FUNC_BYTE, p);
    endtask

    task automatic ignored_item();
        push_item(FUNC_UNKNOWN, random_payload());
    endtask

    // the clock advances first so the last accepted item is already counted in pixels_owed
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pixels_owed != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic set_registers(logic [LEN_W-1:0] root_word, logic [LEN_W-1:0] len);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= REG_ROOT_INDEX;
        i_cfg_data  <= root_word;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= REG_LINE_LENGTH;
        i_cfg_data  <= len;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
    endtask

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        wait (i_rst_n);
        @(posedge i_clk);
        forever begin
            gap = draw_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge i_clk); while (!m_axis_tvalid);
        end
    end

    initial begin
        logic [IDX_W-1:0] root;
        logic [LEN_W-1:0] len;
        i_rst_n       = 1'b0;
        i_cfg_valid   = 1'b0;
        i_cfg_index   = REG_ROOT_INDEX;
        i_cfg_data    = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = FUNC_LOAD;
        steady_flow   = 1'b0;
        items_sent    = 0;
        for (int i = 0; i < NODE_DEPTH; i++) node_written[i] = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extreme nodes, a byte straight out of reset, unknown function
        load_node(10'd5, 1'b1, 10'd1023, 10'd1023, 10'd1023);
        load_node(10'd1023, 1'b1, 10'd0, 10'd0, 10'd0);
        load_node(10'd0, 1'b0, 10'd0, 10'd5, 10'd1023);
        code_byte(8'hA5);
        start_line(8'hFF);
        code_byte(8'h00);
        code_byte(8'hFF);
        push_item(FUNC_UNKNOWN, '{pad: '0, default: '1});
        settle();
        // leaf at the root, short line that fills up
        set_registers(11'h7FF, 11'd3);
        start_line(8'h00);
        code_byte(8'h3C);
        code_byte(8'hC3);
        settle();
        set_registers(11'd0, 11'd0);
        start_line(8'h55);
        code_byte(8'hAA);
        settle();
        set_registers(11'd0, 11'd1);
        start_line(8'h80);
        code_byte(8'h81);
        settle();
        // limit saturates; root moves to a leaf while the walk is mid-line
        set_registers(11'd0, 11'd2047);
        start_line(8'h80);
        code_byte(8'h5A);
        settle();
        set_registers(11'd5, 11'd2047);
        code_byte(8'h00);
        code_byte(8'h7E);
        settle();

        while (items_sent < 155) begin
            steady_flow = ($urandom_range(0, 3) == 0);
            build_tree($urandom_range(1, 6), root);
            repeat ($urandom_range(0, 2)) stray_load();
            if ($urandom_range(0, 3) == 0) ignored_item();
            settle();
            case ($urandom_range(0, 11))
                0:       len = 11'd0;
                1:       len = 11'd1;
                2:       len = 11'd1024;
                3:       len = 11'd2047;
                4:       len = 11'd800;
                5:       len = LEN_W'($urandom_range(0, 2047));
                default: len = LEN_W'($urandom_range(2, 20));
            endcase
            set_registers({1'($urandom_range(0, 1)), root}, len);
            if ($urandom_range(0, 4) == 0) code_byte(PIX_W'($urandom_range(0, 255)));
            repeat ($urandom_range(1, 3)) begin
                start_line(PIX_W'($urandom_range(0, 255)));
                repeat ($urandom_range(1, 6)) begin
                    code_byte(PIX_W'($urandom_range(0, 255)));
                    case ($urandom_range(0, 19))
                        0:       ignored_item();
                        1:       stray_load();
                        default: ;
                    endcase
                end
            end
            settle();
        end

        steady_flow = 1'b0;
        settle();
        if (fail_count == 0)
            $display("tb_huffman_first_difference_decoder_unit OK");
        else
            $display("tb_huffman_first_difference_decoder_unit NOT OK");
        $finish;
    end

endmodule
